/* rtl/gbk_ascii_glyph_fetch_and_expand_unit_defines.svh */
// Assertion helpers for the checks in this unit.
`ifndef GBK_ASCII_GLYPH_FETCH_AND_EXPAND_UNIT_DEFINES_SVH
`define GBK_ASCII_GLYPH_FETCH_AND_EXPAND_UNIT_DEFINES_SVH

// Condition a implies condition b in the same cycle.
`define GBKGF_ASSERT_SAME(label, clk_s, rst_s, a, b) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (a) |-> (b)) \
    else $error("gbkgf check failed: same-cycle implication");

// Condition a implies condition b in the next cycle.
`define GBKGF_ASSERT_NEXT(label, clk_s, rst_s, a, b) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (a) |=> (b)) \
    else $error("gbkgf check failed: next-cycle implication");

`endif

/* rtl/gbkgf_pkg.sv */
package gbkgf_pkg;

  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned COORD_W = 16;

  // Command codes.
  localparam logic [1:0] CMD_SET_CURSOR = 2'd0;
  localparam logic [1:0] CMD_CHAR       = 2'd1;
  localparam logic [1:0] CMD_PIXELS     = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ASCII_BASE = 3'd0;
  localparam logic [2:0] CFG_SMALL_BASE = 3'd1;
  localparam logic [2:0] CFG_LARGE_BASE = 3'd2;
  localparam logic [2:0] CFG_WIDTH      = 3'd3;
  localparam logic [2:0] CFG_FRONT      = 3'd4;
  localparam logic [2:0] CFG_BACK       = 3'd5;

  localparam logic [15:0] WIDTH_RESET = 16'd320;
  localparam logic [15:0] FRONT_RESET = 16'hF800;
  localparam logic [15:0] BACK_RESET  = 16'hFFFF;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] ASCII_FIRST = 8'd32;
  localparam logic [7:0] GBK_HI_FIRST = 8'h81;
  localparam logic [7:0] GBK_LO_FIRST = 8'h40;
  localparam logic [7:0] GBK_LO_GAP   = 8'h7F;
  localparam logic [7:0] GBK_ROW_LEN  = 8'd190;

  localparam logic [5:0] LEN_ASCII = 6'd16;
  localparam logic [5:0] LEN_SMALL = 6'd32;
  localparam logic [5:0] LEN_LARGE = 6'd63;

  typedef struct packed {
    logic [15:0] col;
    logic [15:0] row;
  } cursor_t;

  typedef struct packed {
    logic [23:0] flash_address;
    logic [5:0]  read_length;
    logic [15:0] window_x0;
    logic [15:0] window_y0;
    logic [15:0] window_x1;
    logic [15:0] window_y1;
    logic [1:0]  bytes_used;
  } char_result_t;

endpackage

/* rtl/gbkgf_glyph_calc.sv */
module gbkgf_glyph_calc (
  input  logic                  font_set,
  input  logic [7:0]            code_first,
  input  logic [7:0]            code_second,
  input  gbkgf_pkg::cursor_t    cursor,
  input  logic [23:0]           ascii_font_base,
  input  logic [23:0]           small_gbk_base,
  input  logic [23:0]           large_gbk_base,
  input  logic [15:0]           screen_width,
  output gbkgf_pkg::char_result_t result,
  output gbkgf_pkg::cursor_t    cursor_next
);
  import gbkgf_pkg::*;

  logic        is_ascii;
  logic [23:0] ascii_off;
  logic [23:0] hi_off;
  logic [23:0] row_term;
  logic [23:0] gbk_idx;
  logic [23:0] small_addr;
  logic [23:0] large_addr;
  logic [15:0] glyph_w;
  logic [15:0] glyph_h;
  logic [15:0] step;
  logic [15:0] margin;
  logic [15:0] col_adv;
  logic signed [17:0] wrap_limit;
  logic        wrap;

  assign is_ascii = !font_set && (code_first < ASCII_LIMIT);

  // All index arithmetic runs modulo 2^24, so codes below the table start
  // wrap exactly as a two's complement index would.
  assign ascii_off = {16'd0, code_first} - {16'd0, ASCII_FIRST};
  assign hi_off    = {16'd0, code_first} - {16'd0, GBK_HI_FIRST};
  assign row_term  = hi_off * {16'd0, GBK_ROW_LEN};
  assign gbk_idx   = row_term + {16'd0, code_second} - {16'd0, GBK_LO_FIRST}
                     - {23'd0, (code_second >= GBK_LO_GAP)};
  assign small_addr = small_gbk_base + {gbk_idx[18:0], 5'd0};
  assign large_addr = large_gbk_base + ({gbk_idx[17:0], 6'd0} - gbk_idx);

  always_comb begin
    if (is_ascii) begin
      result.flash_address = ascii_font_base + {ascii_off[19:0], 4'd0};
      result.read_length   = LEN_ASCII;
      result.bytes_used    = 2'd1;
      glyph_w = 16'd8;
      glyph_h = 16'd16;
      step    = 16'd8;
      margin  = 16'd8;
    end else if (!font_set) begin
      result.flash_address = small_addr;
      result.read_length   = LEN_SMALL;
      result.bytes_used    = 2'd2;
      glyph_w = 16'd16;
      glyph_h = 16'd16;
      step    = 16'd16;
      margin  = 16'd15;
    end else begin
      result.flash_address = large_addr;
      result.read_length   = LEN_LARGE;
      result.bytes_used    = 2'd2;
      glyph_w = 16'd24;
      glyph_h = 16'd21;
      step    = 16'd21;
      margin  = 16'd21;
    end
    result.window_x0 = cursor.col;
    result.window_y0 = cursor.row;
    result.window_x1 = cursor.col + glyph_w - 16'd1;
    result.window_y1 = cursor.row + glyph_h - 16'd1;
  end

  // The wrap test is signed, so a screen narrower than the margin always wraps.
  assign col_adv    = cursor.col + step;
  assign wrap_limit = $signed({2'b00, screen_width}) - $signed({2'b00, margin});
  assign wrap       = $signed({2'b00, col_adv}) > wrap_limit;

  always_comb begin
    if (wrap) begin
      cursor_next.col = 16'd0;
      cursor_next.row = cursor.row + glyph_h;
    end else begin
      cursor_next.col = col_adv;
      cursor_next.row = cursor.row;
    end
  end

endmodule

/* rtl/gbkgf_out_stage.sv */
module gbkgf_out_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load_valid,
  input  logic                    load_is_pixel,
  input  gbkgf_pkg::char_result_t load_char,
  input  logic [7:0]              load_glyph,
  output logic                    load_ready,
  input  logic [15:0]             ink_color,
  input  logic [15:0]             paper_color,
  output logic                    out_valid,
  input  logic                    out_ready,
  output gbkgf_pkg::char_result_t out_char,
  output logic [15:0]             pixel_color,
  output logic                    last
);
  import gbkgf_pkg::*;

  logic         valid;
  logic         is_pixel;
  char_result_t chr;
  logic [7:0]   glyph;
  logic [2:0]   count;
  logic         last_beat;
  logic         take;

  assign last_beat  = !is_pixel || (count == 3'd7);
  assign take       = valid && out_ready;
  assign load_ready = !valid || (out_ready && last_beat);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      count <= 3'd0;
    end else if (load_valid && load_ready) begin
      valid <= 1'b1;
      count <= 3'd0;
    end else if (take) begin
      if (last_beat) begin
        valid <= 1'b0;
      end else begin
        count <= count + 3'd1;
      end
    end
  end

  // The glyph byte shifts left one bit per pixel, so bit 7 is always current.
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      is_pixel <= load_is_pixel;
      chr      <= load_char;
      glyph    <= load_glyph;
    end else if (take && !last_beat) begin
      glyph <= {glyph[6:0], 1'b0};
    end
  end

  assign out_valid = valid;

  always_comb begin
    if (is_pixel) begin
      out_char    = '0;
      pixel_color = glyph[7] ? ink_color : paper_color;
      last        = (count == 3'd7);
    end else begin
      out_char    = chr;
      pixel_color = 16'd0;
      last        = 1'b1;
    end
  end

endmodule

/* rtl/gbk_ascii_glyph_fetch_and_expand_unit.sv */
// An item enters the input register, then the result register once that can load.
// Throughput: one item per cycle while out_ready is high; a character gives one result
// per cycle; a glyph byte holds the result register for eight pixels, one per cycle.
// Set-cursor items give no result and never wait on the result register.
// Synchronous active-high reset clears the cursor, the valid flags and loads the
// register defaults (bases 0, width 320, front 0xF800, back 0xFFFF).
module gbk_ascii_glyph_fetch_and_expand_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic        font_set,
  input  logic [7:0]  code_first,
  input  logic [7:0]  code_second,
  input  logic [7:0]  glyph_byte,
  input  logic [15:0] new_x,
  input  logic [15:0] new_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] flash_address,
  output logic [5:0]  read_length,
  output logic [15:0] window_x0,
  output logic [15:0] window_y0,
  output logic [15:0] window_x1,
  output logic [15:0] window_y1,
  output logic [1:0]  bytes_used,
  output logic [15:0] pixel_color,
  output logic        last
);
  import gbkgf_pkg::*;
  `include "gbk_ascii_glyph_fetch_and_expand_unit_defines.svh"

  logic [23:0] ascii_font_base;
  logic [23:0] small_gbk_base;
  logic [23:0] large_gbk_base;
  logic [15:0] screen_width;
  logic [15:0] ink_color;
  logic [15:0] paper_color;

  logic        s1_valid;
  logic [1:0]  s1_cmd;
  logic        s1_font_set;
  logic [7:0]  s1_code_first;
  logic [7:0]  s1_code_second;
  logic [7:0]  s1_glyph;
  logic [15:0] s1_x;
  logic [15:0] s1_y;

  cursor_t      cursor;
  cursor_t      cursor_adv;
  char_result_t char_res;
  char_result_t out_char;
  logic         s1_produces;
  logic         load_ready;
  logic         s1_consume;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ascii_font_base <= 24'd0;
      small_gbk_base  <= 24'd0;
      large_gbk_base  <= 24'd0;
      screen_width    <= WIDTH_RESET;
      ink_color       <= FRONT_RESET;
      paper_color     <= BACK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ASCII_BASE: ascii_font_base <= cfg_data;
        CFG_SMALL_BASE: small_gbk_base  <= cfg_data;
        CFG_LARGE_BASE: large_gbk_base  <= cfg_data;
        CFG_WIDTH:      screen_width    <= cfg_data[15:0];
        CFG_FRONT:      ink_color       <= cfg_data[15:0];
        CFG_BACK:       paper_color     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign s1_produces = (s1_cmd == CMD_CHAR) || (s1_cmd == CMD_PIXELS);
  assign s1_consume  = s1_valid && (!s1_produces || load_ready);
  assign in_ready    = !s1_valid || s1_consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_consume) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd         <= cmd;
      s1_font_set    <= font_set;
      s1_code_first  <= code_first;
      s1_code_second <= code_second;
      s1_glyph       <= glyph_byte;
      s1_x           <= new_x;
      s1_y           <= new_y;
    end
  end

  // The cursor moves when a set-cursor or character item leaves the input register,
  // which keeps its updates in item order.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (s1_consume) begin
      if (s1_cmd == CMD_SET_CURSOR) begin
        cursor.col <= s1_x;
        cursor.row <= s1_y;
      end else if (s1_cmd == CMD_CHAR) begin
        cursor <= cursor_adv;
      end
    end
  end

  gbkgf_glyph_calc u_calc (
    .font_set        (s1_font_set),
    .code_first      (s1_code_first),
    .code_second     (s1_code_second),
    .cursor          (cursor),
    .ascii_font_base (ascii_font_base),
    .small_gbk_base  (small_gbk_base),
    .large_gbk_base  (large_gbk_base),
    .screen_width    (screen_width),
    .result          (char_res),
    .cursor_next     (cursor_adv)
  );

  gbkgf_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load_valid    (s1_valid && s1_produces),
    .load_is_pixel (s1_cmd == CMD_PIXELS),
    .load_char     (char_res),
    .load_glyph    (s1_glyph),
    .load_ready    (load_ready),
    .ink_color     (ink_color),
    .paper_color   (paper_color),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .pixel_color   (pixel_color),
    .last          (last)
  );

  assign flash_address = out_char.flash_address;
  assign read_length   = out_char.read_length;
  assign window_x0     = out_char.window_x0;
  assign window_y0     = out_char.window_y0;
  assign window_x1     = out_char.window_x1;
  assign window_y1     = out_char.window_y1;
  assign bytes_used    = out_char.bytes_used;

  `GBKGF_ASSERT_NEXT(a_accept_fills_s1, clk, rst, in_valid && in_ready, s1_valid)
  `GBKGF_ASSERT_SAME(a_char_is_last, clk, rst, out_valid && read_length != 6'd0, last)
  `GBKGF_ASSERT_NEXT(a_burst_continues, clk, rst, out_valid && out_ready && !last,
                     out_valid)
  `GBKGF_ASSERT_SAME(a_pixel_no_length, clk, rst, out_valid && !last,
                     read_length == 6'd0 && bytes_used == 2'd0)

endmodule
